// ----- hdl/nts_pkg.sv -----
// ---------------------------------------------------------------------------
// nts_pkg
// Shared constants and types for the neighbor table and parent selection.
// ---------------------------------------------------------------------------
package nts_pkg;

   localparam int ENTRIES   = 8;
   localparam int IDX_W     = $clog2(ENTRIES);
   localparam int ADDR_W    = 16;
   localparam int HOPS_W    = 7;
   localparam int TICK_W    = 8;
   localparam int HOP_LIMIT = 16;

   localparam logic [ADDR_W-1:0] EMPTY_ADDR    = 16'hFF80;
   localparam logic [HOPS_W-1:0] EMPTY_HOPS    = HOPS_W'(HOP_LIMIT + 1);
   localparam logic [HOPS_W-1:0] HOPS_LIMIT    = HOPS_W'(HOP_LIMIT);
   localparam logic [HOPS_W-1:0] HOPS_MAX      = '1;
   localparam logic [HOPS_W-1:0] TIMEOUT_RESET = 7'd6;

   localparam logic ACTION_PACKET = 1'b0;
   localparam logic ACTION_TICK   = 1'b1;

   typedef enum logic {
      CSR_LOCAL_ADDRESS  = 1'b0,
      CSR_PARENT_TIMEOUT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_HEARD,
      OP_PURGE,
      OP_FILL,
      OP_SWEEP
   } cell_op_type;

   typedef struct packed {
      cell_op_type       op;
      logic [IDX_W-1:0]  slot;
      logic [ADDR_W-1:0] addr;
      logic [HOPS_W-1:0] hops;
   } cell_cmd_type;

   typedef struct packed {
      logic              hit_found;
      logic [IDX_W-1:0]  hit_idx;
      logic              srch_found;
      logic [IDX_W-1:0]  srch_idx;
      logic [HOPS_W-1:0] srch_hops;
      logic [ADDR_W-1:0] srch_addr;
      logic [ADDR_W-1:0] par_addr;
      logic [HOPS_W-1:0] par_hops;
      logic              par_heard;
   } chain_type;

   function automatic logic [HOPS_W-1:0] hops_plus_one(input logic [HOPS_W-1:0] h);
      return (h == HOPS_MAX) ? HOPS_MAX : h + 1'b1;
   endfunction

endpackage

// ----- hdl/nts_cell.sv -----
// ---------------------------------------------------------------------------
// nts_cell
// One neighbor entry: address, hop count and heard flag, with its link in
// the lookup, parent search and parent read chain.
// ---------------------------------------------------------------------------
module nts_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [nts_pkg::IDX_W-1:0]  cell_idx,
   input  nts_pkg::cell_cmd_type      cmd,
   input  logic [nts_pkg::ADDR_W-1:0] key_addr,
   input  logic [nts_pkg::IDX_W-1:0]  parent_slot,
   input  logic                       excl_parent,
   input  nts_pkg::chain_type         chain_in,
   output nts_pkg::chain_type         chain_out
);
   import nts_pkg::*;

   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [HOPS_W-1:0] hops_ff, hops_in;
   logic              heard_ff, heard_in;
   logic              mine;
   logic              is_parent;
   logic              qualify;

   assign mine      = (cmd.slot == cell_idx);
   assign is_parent = (parent_slot == cell_idx);
   assign qualify   = heard_ff && (hops_ff < HOPS_LIMIT) && !(excl_parent && is_parent);

   always_comb begin
      chain_out = chain_in;
      if (!chain_in.hit_found && addr_ff == key_addr) begin
         chain_out.hit_found = 1'b1;
         chain_out.hit_idx   = cell_idx;
      end
      if (!chain_in.srch_found && qualify) begin
         chain_out.srch_found = 1'b1;
         chain_out.srch_idx   = cell_idx;
         chain_out.srch_hops  = hops_ff;
         chain_out.srch_addr  = addr_ff;
      end
      if (is_parent) begin
         chain_out.par_addr  = addr_ff;
         chain_out.par_hops  = hops_ff;
         chain_out.par_heard = heard_ff;
      end
   end

   always_comb begin
      addr_in  = addr_ff;
      hops_in  = hops_ff;
      heard_in = heard_ff;
      unique case (cmd.op)
         OP_HEARD: begin
            if (mine) begin
               hops_in  = cmd.hops;
               heard_in = 1'b1;
            end
         end
         OP_PURGE: begin
            if (mine) begin
               addr_in  = EMPTY_ADDR;
               hops_in  = cmd.hops;
               heard_in = 1'b1;
            end
         end
         OP_FILL: begin
            if (mine) begin
               addr_in  = cmd.addr;
               hops_in  = cmd.hops;
               heard_in = 1'b1;
            end
         end
         OP_SWEEP: begin
            if (!heard_ff) begin
               addr_in = EMPTY_ADDR;
               hops_in = EMPTY_HOPS;
            end
            heard_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff  <= EMPTY_ADDR;
         hops_ff  <= EMPTY_HOPS;
         heard_ff <= 1'b0;
      end else begin
         addr_ff  <= addr_in;
         hops_ff  <= hops_in;
         heard_ff <= heard_in;
      end
   end

endmodule

// ----- hdl/neighbor_table_parent_select_top.sv -----
// ---------------------------------------------------------------------------
// neighbor_table_parent_select_top
// Neighbor cache of eight entries with routing parent selection and aging.
// ---------------------------------------------------------------------------
// the request beat is registered into execute; execute runs the lookup through
// the cell chain, updates the cells and registers the result beat, and it waits
//   while an older result is still unaccepted; no new beat is taken until then
// reset: synchronous; every entry reads empty, no parent, hops 17, right away
module neighbor_table_parent_select_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // sender_addr[15:0], sender_hops[22:16], dest_addr[38:23]
   input  logic [39:0] req_tdata,
   // action[0]
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // forward[0], next_hop[16:1], our_hops[23:17], have_parent[24], new_parent[25]
   output logic [31:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import nts_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type         state_ff;
   logic              rsp_valid_ff;
   logic [31:0]       rsp_data_ff;

   logic              action_ff;
   logic [ADDR_W-1:0] saddr_ff;
   logic [HOPS_W-1:0] shops_ff;
   logic [ADDR_W-1:0] daddr_ff;

   logic [ADDR_W-1:0] local_addr_ff;
   logic [HOPS_W-1:0] timeout_ff;

   logic              pv_ff, pv_in;
   logic [IDX_W-1:0]  ps_ff, ps_in;
   logic [HOPS_W-1:0] hd_ff, hd_in;
   logic [IDX_W-1:0]  fp_ff, fp_in;
   logic [TICK_W-1:0] tick_ff, tick_in;

   chain_type         chain_w [ENTRIES+1];
   chain_type         ch;
   cell_cmd_type      cmd;

   logic              commit;
   logic              is_pkt, own, known, purge, fill, take, sweep, reselect, search_use;
   logic              fwd;
   logic [ADDR_W-1:0] next_hop;
   logic [31:0]       rsp_data_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign commit     = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);

   assign chain_w[0] = '0;
   assign ch         = chain_w[ENTRIES];

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      nts_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_idx    (IDX_W'(i)),
         .cmd         (cmd),
         .key_addr    (saddr_ff),
         .parent_slot (ps_ff),
         .excl_parent (is_pkt),
         .chain_in    (chain_w[i]),
         .chain_out   (chain_w[i+1])
      );
   end

   // decision logic for the item in execute
   always_comb begin
      is_pkt     = (action_ff == ACTION_PACKET);
      own        = (saddr_ff == local_addr_ff);
      known      = is_pkt && !own && ch.hit_found;
      fill       = is_pkt && !own && !ch.hit_found;
      purge      = known && pv_ff && (ch.hit_idx == ps_ff) && (shops_ff >= hd_ff);
      take       = fill && (pv_ff ? ((fp_ff != ps_ff) && (shops_ff < ch.par_hops))
                                  : (shops_ff < HOPS_LIMIT));
      sweep      = !is_pkt && (tick_ff > {1'b0, timeout_ff});
      reselect   = sweep && (!pv_ff || !ch.par_heard);
      search_use = purge || reselect;

      cmd.op   = OP_NOP;
      cmd.slot = ch.hit_idx;
      cmd.addr = saddr_ff;
      cmd.hops = shops_ff;
      if (commit) begin
         priority if (purge) begin
            cmd.op = OP_PURGE;
         end else if (known) begin
            cmd.op = OP_HEARD;
         end else if (fill) begin
            cmd.op   = OP_FILL;
            cmd.slot = fp_ff;
         end else if (sweep) begin
            cmd.op = OP_SWEEP;
         end
      end

      pv_in = pv_ff;
      ps_in = ps_ff;
      hd_in = hd_ff;
      if (take) begin
         pv_in = 1'b1;
         ps_in = fp_ff;
         hd_in = hops_plus_one(shops_ff);
      end else if (search_use) begin
         pv_in = ch.srch_found;
         if (ch.srch_found) begin
            ps_in = ch.srch_idx;
            hd_in = hops_plus_one(ch.srch_hops);
         end
      end

      fp_in = fp_ff;
      if (fill) begin
         fp_in = (fp_ff == IDX_W'(ENTRIES - 1)) ? '0 : fp_ff + 1'b1;
      end

      tick_in = tick_ff;
      if (!is_pkt) begin
         tick_in = (sweep ? '0 : tick_ff) + 1'b1;
      end

      next_hop = '0;
      if (pv_in) begin
         priority if (take) begin
            next_hop = saddr_ff;
         end else if (search_use) begin
            next_hop = ch.srch_addr;
         end else if (fill && fp_ff == ps_ff) begin
            next_hop = saddr_ff;
         end else begin
            next_hop = ch.par_addr;
         end
      end

      fwd = is_pkt && (daddr_ff == local_addr_ff) && pv_in && (hd_in <= HOPS_LIMIT);

      rsp_data_in = {6'b0, take, pv_in, hd_in, next_hop, fwd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff   <= 1'b0;
         ps_ff   <= '0;
         hd_ff   <= EMPTY_HOPS;
         fp_ff   <= '0;
         tick_ff <= '0;
      end else if (commit) begin
         pv_ff   <= pv_in;
         ps_ff   <= ps_in;
         hd_ff   <= hd_in;
         fp_ff   <= fp_in;
         tick_ff <= tick_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_addr_ff <= '0;
         timeout_ff    <= TIMEOUT_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_LOCAL_ADDRESS:  local_addr_ff <= csr_wdata;
            CSR_PARENT_TIMEOUT: timeout_ff    <= csr_wdata[HOPS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  state_ff  <= ST_EXEC;
                  action_ff <= req_tuser[0];
                  saddr_ff  <= req_tdata[15:0];
                  shops_ff  <= req_tdata[22:16];
                  daddr_ff  <= req_tdata[38:23];
               end
            end
            ST_EXEC: begin
               if (commit) begin
                  state_ff    <= ST_IDLE;
                  rsp_data_ff <= rsp_data_in;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_EXEC))
      else $error("accepted beat did not enter execute");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_EXEC))
      else $error("result raised without an execute cycle");

   a_new_parent_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[25]) |-> rsp_tdata[24])
      else $error("new parent reported without a parent");

   a_forward_parent: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> (rsp_tdata[24] && rsp_tdata[23:17] <= HOPS_LIMIT))
      else $error("forward without a usable parent");
`endif

endmodule
